### hw/rtl/mprq_pkg.sv
// package for the multilevel priority ready queue
// holds sizes, status and mode codes, and the controller/datapath link types
// no dependencies

package mprq_pkg;

  localparam int unsigned Levels = 5;
  localparam int unsigned Depth = 16;
  localparam int unsigned IdW = 8;

  localparam int unsigned LvW = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned MemDepth = Levels * Depth;
  localparam int unsigned MemAw = $clog2(MemDepth);

  localparam logic [1:0] StatusEnq = 2'd0;
  localparam logic [1:0] StatusDeq = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;
  localparam logic [1:0] StatusFull = 2'd3;

  localparam logic ModeEnq = 1'b0;
  localparam logic ModeDeq = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] thread_id;
    logic [2:0] base_priority;
    logic       temp_priority_valid;
    logic [2:0] temp_priority;
  } item_t;

  typedef struct packed {
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/mprq_ctrl.sv
// controller of the multilevel priority ready queue
// two-state sequencer issuing execute and load commands to the datapath
// depends on mprq_pkg

module mprq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mprq_pkg::sts_t sts_i,
  output mprq_pkg::cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StFinish = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.exec = 1'b0;
    cmd_o.load = 1'b0;
    case (state_q)
      StIdle: begin
        cmd_o.exec = in_valid_i;
        if (in_valid_i) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        cmd_o.load = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_exec_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> (state_q == StFinish))
    else $error("exec did not move to finish");

  a_no_exec_and_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.exec && cmd_o.load))
    else $error("exec and load together");

  a_load_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> in_ready_o)
    else $error("load did not return to idle");

endmodule

### hw/rtl/mprq_dpath.sv
// datapath of the multilevel priority ready queue
// per-level pointers and counts, entry memory, pending result and output register
// depends on mprq_pkg

module mprq_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mprq_pkg::cmd_t       cmd_i,
  output mprq_pkg::sts_t       sts_o,
  input  mprq_pkg::item_t      item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_status_o,
  output logic [7:0]           out_thread_o,
  output logic [2:0]           out_level_o
);

  logic [mprq_pkg::IdW-1:0] mem_q [mprq_pkg::MemDepth];
  logic [mprq_pkg::IdW-1:0] rd_q;

  logic [mprq_pkg::Levels-1:0][mprq_pkg::PtrW-1:0] head_q, head_d;
  logic [mprq_pkg::Levels-1:0][mprq_pkg::PtrW-1:0] tail_q, tail_d;
  logic [mprq_pkg::Levels-1:0][mprq_pkg::CntW-1:0] cnt_q, cnt_d;

  logic [1:0]                pend_status_q, pend_status_d;
  logic [mprq_pkg::LvW-1:0]  pend_level_q, pend_level_d;

  logic                      out_valid_q;
  logic [1:0]                out_status_q;
  logic [7:0]                out_thread_q;
  logic [2:0]                out_level_q;

  logic [2:0]                sel_prio;
  logic [mprq_pkg::LvW-1:0]  enq_lv;
  logic [mprq_pkg::LvW-1:0]  deq_lv;
  logic                      deq_found;
  logic                      enq_full;
  logic                      mem_we;
  logic                      mem_re;
  logic [mprq_pkg::MemAw-1:0] mem_addr;
  logic [mprq_pkg::PtrW-1:0] ptr;
  logic                      any_over;

  function automatic logic [mprq_pkg::PtrW-1:0] wrap_inc(
    input logic [mprq_pkg::PtrW-1:0] p
  );
    logic [mprq_pkg::PtrW-1:0] r;
    if (p == mprq_pkg::PtrW'(mprq_pkg::Depth - 1)) begin
      r = '0;
    end else begin
      r = p + mprq_pkg::PtrW'(1);
    end
    return r;
  endfunction

  // level pick with saturation
  always_comb begin
    sel_prio = item_i.temp_priority_valid ? item_i.temp_priority : item_i.base_priority;
    if (5'(sel_prio) >= 5'(mprq_pkg::Levels)) begin
      enq_lv = mprq_pkg::LvW'(mprq_pkg::Levels - 1);
    end else begin
      enq_lv = mprq_pkg::LvW'(sel_prio);
    end
    enq_full = (cnt_q[enq_lv] >= mprq_pkg::CntW'(mprq_pkg::Depth));
  end

  // highest non-empty level
  always_comb begin
    deq_lv = '0;
    deq_found = 1'b0;
    for (int unsigned i = 0; i < mprq_pkg::Levels; i++) begin
      if (cnt_q[i] != '0) begin
        deq_lv = mprq_pkg::LvW'(i);
        deq_found = 1'b1;
      end
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d = cnt_q;
    pend_status_d = pend_status_q;
    pend_level_d = pend_level_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    ptr = '0;
    mem_addr = '0;
    if (cmd_i.exec) begin
      if (item_i.mode == mprq_pkg::ModeEnq) begin
        pend_level_d = enq_lv;
        ptr = tail_q[enq_lv];
        mem_addr = mprq_pkg::MemAw'(enq_lv) * mprq_pkg::MemAw'(mprq_pkg::Depth)
                   + mprq_pkg::MemAw'(ptr);
        if (enq_full) begin
          pend_status_d = mprq_pkg::StatusFull;
        end else begin
          pend_status_d = mprq_pkg::StatusEnq;
          mem_we = 1'b1;
          tail_d[enq_lv] = wrap_inc(ptr);
          cnt_d[enq_lv] = cnt_q[enq_lv] + mprq_pkg::CntW'(1);
        end
      end else begin
        ptr = head_q[deq_lv];
        mem_addr = mprq_pkg::MemAw'(deq_lv) * mprq_pkg::MemAw'(mprq_pkg::Depth)
                   + mprq_pkg::MemAw'(ptr);
        if (deq_found) begin
          pend_status_d = mprq_pkg::StatusDeq;
          pend_level_d = deq_lv;
          mem_re = 1'b1;
          head_d[deq_lv] = wrap_inc(ptr);
          cnt_d[deq_lv] = cnt_q[deq_lv] - mprq_pkg::CntW'(1);
        end else begin
          pend_status_d = mprq_pkg::StatusEmpty;
          pend_level_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mprq_pkg::IdW'(item_i.thread_id);
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q <= cnt_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_level_q <= pend_level_d;
    if (cmd_i.load) begin
      out_status_q <= pend_status_q;
      out_level_q <= 3'(pend_level_q);
      out_thread_q <= (pend_status_q == mprq_pkg::StatusDeq) ? 8'(rd_q) : 8'd0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_thread_o = out_thread_q;
  assign out_level_o = out_level_q;

  always_comb begin
    any_over = 1'b0;
    for (int unsigned i = 0; i < mprq_pkg::Levels; i++) begin
      if (cnt_q[i] > mprq_pkg::CntW'(mprq_pkg::Depth)) begin
        any_over = 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_over)
    else $error("level count beyond depth");

  a_full_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && item_i.mode == mprq_pkg::ModeEnq && enq_full)
    |=> ($stable(cnt_q) && $stable(tail_q) && pend_status_q == mprq_pkg::StatusFull))
    else $error("dropped enqueue changed state");

  a_empty_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && item_i.mode == mprq_pkg::ModeDeq && !deq_found)
    |=> (pend_status_q == mprq_pkg::StatusEmpty && $stable(head_q)))
    else $error("empty dequeue misreported");

  a_thread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != mprq_pkg::StatusDeq) |-> (out_thread_q == 8'd0))
    else $error("thread id on non-dequeue beat");

endmodule

### hw/rtl/multilevel_priority_ready_queue.sv
// Strict-priority ready queue: one FIFO of thread ids per priority level, the
// highest level served first. In the idle state an item is accepted, its level
// picked and that level's pointers and count updated while the entry memory is
// read or written; in the finish state the registered memory read moves into the
// output register once that register is free. No new beat is taken until the
// last one has reached the output register. A full level drops the enqueue with
// status 3; a dequeue with every level empty returns status 2.
// depends on mprq_pkg, mprq_ctrl, mprq_dpath

module multilevel_priority_ready_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // thread_id, base_priority, temp_priority_valid, temp_priority
  input  logic [0:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // next_thread, served_level
  output logic [1:0]  m_axis_tuser   // status
);

  mprq_pkg::item_t item;
  mprq_pkg::cmd_t  cmd;
  mprq_pkg::sts_t  sts;
  logic [7:0]      out_thread;
  logic [2:0]      out_level;

  always_comb begin
    item.mode = s_axis_tuser[0];
    item.thread_id = s_axis_tdata[7:0];
    item.base_priority = s_axis_tdata[10:8];
    item.temp_priority_valid = s_axis_tdata[11];
    item.temp_priority = s_axis_tdata[14:12];
  end

  mprq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mprq_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_thread_o (out_thread),
    .out_level_o  (out_level)
  );

  assign m_axis_tdata = {5'd0, out_level, out_thread};

endmodule
